/* src/mcvg_pkg.sv */
// ----------------------------------------------------------------------------
// mcvg_pkg
// Shared widths for the mass-change velocity gradient pipeline.
// ----------------------------------------------------------------------------
package mcvg_pkg;

    // one signed fixed point word
    localparam int WORD_W = 32;
    // sum of squares of the normalised gradient
    localparam int SQ_W = 64;
    // root steps: one result bit per step
    localparam int ROOT_STEPS = 32;
    // width of the mixing register
    localparam int MIX_W = 17;
    // gradient components
    localparam int N_GRAD = 3;

endpackage

/* src/mcvg_div.sv */
// ----------------------------------------------------------------------------
// mcvg_div
// Pipelined unsigned restoring divider, one quotient bit per stage, with a
// shared divisor over several lanes and a sideband that travels alongside.
// The caller splits the dividend so that the upper part is below the divisor.
// ----------------------------------------------------------------------------
module mcvg_div #(
    parameter int LANES = 1,
    parameter int DW    = 32,
    parameter int QW    = 32,
    parameter int SW    = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [LANES-1:0][DW-1:0]      num_hi,
    input  logic [LANES-1:0][QW-1:0]      num_lo,
    input  logic [DW-1:0]                 den,
    input  logic [SW-1:0]                 side_in,
    output logic                          out_valid,
    output logic [LANES-1:0][QW-1:0]      quo,
    output logic [SW-1:0]                 side_out
);

    logic [LANES-1:0][DW-1:0] rem_reg  [QW];
    logic [LANES-1:0][QW-1:0] low_reg  [QW];
    logic [DW-1:0]            den_reg  [QW];
    logic [SW-1:0]            side_reg [QW];
    logic [QW-1:0]            vld_reg;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [LANES-1:0][DW-1:0] rem_in;
        logic [LANES-1:0][QW-1:0] low_in;
        logic [DW-1:0]            den_in;
        logic [SW-1:0]            side_s;
        logic                     vld_in;
        logic [LANES-1:0][DW-1:0] rem_next;
        logic [LANES-1:0][QW-1:0] low_next;

        // stage input: ports for the first stage, previous stage otherwise
        if (k == 0) begin : g_first
            assign rem_in = num_hi;
            assign low_in = num_lo;
            assign den_in = den;
            assign side_s = side_in;
            assign vld_in = in_valid;
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign low_in = low_reg[k-1];
            assign den_in = den_reg[k-1];
            assign side_s = side_reg[k-1];
            assign vld_in = vld_reg[k-1];
        end

        // one trial subtraction per lane
        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [DW:0] trial;
            logic [DW:0] diff;
            logic        ge;
            assign trial       = {rem_in[l], low_in[l][QW-1]};
            assign diff        = trial - {1'b0, den_in};
            assign ge          = trial >= {1'b0, den_in};
            assign rem_next[l] = ge ? diff[DW-1:0] : trial[DW-1:0];
            assign low_next[l] = {low_in[l][QW-2:0], ge};
        end

        // valid bit
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in;
            end
        end

        // payload
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                low_reg[k]  <= low_next;
                den_reg[k]  <= den_in;
                side_reg[k] <= side_s;
            end
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign quo       = low_reg[QW-1];
    assign side_out  = side_reg[QW-1];

endmodule

/* src/mcvg_sqrt.sv */
// ----------------------------------------------------------------------------
// mcvg_sqrt
// Pipelined integer square root of a 64-bit value, one root bit per stage,
// with a sideband that travels alongside.
// ----------------------------------------------------------------------------
module mcvg_sqrt #(
    parameter int SW = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [mcvg_pkg::SQ_W-1:0]     radicand,
    input  logic [SW-1:0]                 side_in,
    output logic                          out_valid,
    output logic [mcvg_pkg::WORD_W-1:0]   root,
    output logic [SW-1:0]                 side_out
);

    localparam int N  = mcvg_pkg::ROOT_STEPS;
    localparam int VW = mcvg_pkg::SQ_W;

    logic [VW-1:0] v_reg    [N];
    logic [VW-1:0] r_reg    [N];
    logic [SW-1:0] side_reg [N];
    logic [N-1:0]  vld_reg;

    for (genvar k = 0; k < N; k++) begin : g_stage
        localparam logic [VW-1:0] BIT = VW'(1) << (VW - 2 - 2 * k);
        logic [VW-1:0] v_in;
        logic [VW-1:0] r_in;
        logic [SW-1:0] side_s;
        logic          vld_in;
        logic [VW-1:0] sum;
        logic          ge;

        if (k == 0) begin : g_first
            assign v_in   = radicand;
            assign r_in   = '0;
            assign side_s = side_in;
            assign vld_in = in_valid;
        end else begin : g_next
            assign v_in   = v_reg[k-1];
            assign r_in   = r_reg[k-1];
            assign side_s = side_reg[k-1];
            assign vld_in = vld_reg[k-1];
        end

        // trial subtraction of the candidate bit
        assign sum = r_in + BIT;
        assign ge  = v_in >= sum;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                v_reg[k]    <= ge ? v_in - sum : v_in;
                r_reg[k]    <= ge ? (r_in >> 1) + BIT : r_in >> 1;
                side_reg[k] <= side_s;
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign root      = r_reg[N-1][mcvg_pkg::WORD_W-1:0];
    assign side_out  = side_reg[N-1];

endmodule

/* src/mass_change_velocity_gradient.sv */
// ----------------------------------------------------------------------------
// mass_change_velocity_gradient
// Velocity gradient from a mass change rate and its gradient: trace, unit
// direction, mixing of spherical and directional parts, saturated output.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)                          | tuser
//  s_       | in  | density, rate, grad_x, grad_y, grad_z       | -
//  m_       | out | l_xx..l_zz (row major), trace_out           | bad_density
//  cfg_wr_  | in  | mixing (17 bits)                            | -
//
//  One item per cycle while m_ does not stall; the path runs through the three
//  long-division pipelines (trace, unit vector, a) and the 32-step root.
//  Reset clears every valid bit and the mixing register.
//  A stall at m_ holds the whole pipeline; s_tready drops in the same cycle.
// ----------------------------------------------------------------------------
module mass_change_velocity_gradient #(
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [16:0]  cfg_wr_data,  // mixing
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [159:0] s_tdata,      // density, rate, grad_x, grad_y, grad_z
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [319:0] m_tdata,      // l_xx .. l_zz, trace_out
    output logic [0:0]   m_tuser       // bad_density
);

    localparam int F   = FRAC_BITS;
    localparam int W   = mcvg_pkg::WORD_W;
    localparam int NG  = mcvg_pkg::N_GRAD;
    localparam int QT  = W + F;
    localparam int CW  = (mcvg_pkg::MIX_W > F + 1) ? mcvg_pkg::MIX_W : F + 1;
    localparam int TSW = 2 + NG * W;
    localparam int RSW = 2 + NG + W + NG * W;
    localparam int NSW = 2 + NG + W;
    localparam int ASW = 2 + W + NG + NG * (F + 1);
    localparam logic [CW-1:0] ONE_C   = CW'(1) << F;
    localparam logic [F:0]    ONE_D   = {1'b1, {F{1'b0}}};
    localparam logic [QT-1:0] POS_LIM = QT'(64'h7FFF_FFFF);
    localparam logic [QT-1:0] NEG_LIM = QT'(64'h8000_0000);

    // saturate a 34-bit signed sum to 32 bits
    function automatic logic [31:0] sat34(input logic signed [33:0] v);
        logic [31:0] r;
        if (v > 34'sh0_7FFF_FFFF) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -34'sh0_8000_0000) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // mixing register, clamped to one
    logic [mcvg_pkg::MIX_W-1:0] mixing_reg;
    logic [CW-1:0]              mix_ext;
    logic [F:0]                 d_clamp;
    logic [F:0]                 one_minus_d;
    logic [F+1:0]               a_den;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mixing_reg <= '0;
        end else if (cfg_wr_en) begin
            mixing_reg <= cfg_wr_data;
        end
    end

    assign mix_ext     = CW'(mixing_reg);
    assign d_clamp     = (mix_ext > ONE_C) ? ONE_D : mix_ext[F:0];
    assign one_minus_d = ONE_D - d_clamp;
    assign a_den       = {2'b11, {F{1'b0}}} - {d_clamp, 1'b0};

    // input unpacking and trace division
    logic [W-1:0]  in_density;
    logic [W-1:0]  in_rate;
    logic [W-1:0]  in_rate_mag;
    logic          in_bad;
    logic [QT-1:0] td_q;
    logic [TSW-1:0] td_side;
    logic          td_valid;

    assign in_density  = s_tdata[31:0];
    assign in_rate     = s_tdata[63:32];
    assign in_rate_mag = in_rate[W-1] ? ~in_rate + 1'b1 : in_rate;
    assign in_bad      = in_density[W-1] || (in_density == '0);

    mcvg_div #(.LANES(1), .DW(W), .QW(QT), .SW(TSW)) u_trace_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .num_hi    ('0),
        .num_lo    ({in_rate_mag, {F{1'b0}}}),
        .den       (in_density),
        .side_in   ({in_bad, in_rate[W-1], s_tdata[159:64]}),
        .out_valid (td_valid),
        .quo       (td_q),
        .side_out  (td_side)
    );

    // stage t1: trace saturation, gradient magnitudes and the largest
    logic                  t1_vld_reg;
    logic                  t1_bad_reg;
    logic                  t1_zg_reg;
    logic [NG-1:0]         t1_gsign_reg;
    logic [W-1:0]          t1_trace_reg;
    logic [NG-1:0][W-1:0]  t1_mag_reg;
    logic [W-1:0]          t1_largest_reg;
    logic [NG-1:0][W-1:0]  t1_g;
    logic [NG-1:0][W-1:0]  t1_mag_next;
    logic [W-1:0]          t1_largest_next;
    logic [W-1:0]          t1_trace_next;

    assign t1_g = td_side[NG*W-1:0];

    always_comb begin
        t1_largest_next = '0;
        for (int i = 0; i < NG; i++) begin
            t1_mag_next[i] = t1_g[i][W-1] ? ~t1_g[i] + 1'b1 : t1_g[i];
            if (t1_mag_next[i] > t1_largest_next) begin
                t1_largest_next = t1_mag_next[i];
            end
        end
        if (td_side[TSW-2]) begin
            t1_trace_next = (td_q > NEG_LIM) ? 32'h8000_0000 : ~td_q[W-1:0] + 1'b1;
        end else begin
            t1_trace_next = (td_q > POS_LIM) ? 32'h7FFF_FFFF : td_q[W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t1_vld_reg <= 1'b0;
        end else if (en) begin
            t1_vld_reg <= td_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t1_bad_reg     <= td_side[TSW-1];
            t1_zg_reg      <= (t1_largest_next == '0);
            for (int i = 0; i < NG; i++) begin
                t1_gsign_reg[i] <= t1_g[i][W-1];
            end
            t1_trace_reg   <= t1_trace_next;
            t1_mag_reg     <= t1_mag_next;
            t1_largest_reg <= t1_largest_next;
        end
    end

    // stage t2: normalising shift amount
    logic                  t2_vld_reg;
    logic                  t2_bad_reg;
    logic                  t2_zg_reg;
    logic [NG-1:0]         t2_gsign_reg;
    logic [W-1:0]          t2_trace_reg;
    logic [NG-1:0][W-1:0]  t2_mag_reg;
    logic [4:0]            t2_shift_reg;
    logic [4:0]            t2_msb;
    logic [4:0]            t2_shift_next;

    always_comb begin
        t2_msb = '0;
        for (int i = 0; i < W; i++) begin
            if (t1_largest_reg[i]) begin
                t2_msb = 5'(i);
            end
        end
        if (t1_largest_reg[W-1] || t1_largest_reg[W-2]) begin
            t2_shift_next = '0;
        end else begin
            t2_shift_next = 5'(W - 2) - t2_msb;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t2_vld_reg <= 1'b0;
        end else if (en) begin
            t2_vld_reg <= t1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t2_bad_reg   <= t1_bad_reg;
            t2_zg_reg    <= t1_zg_reg;
            t2_gsign_reg <= t1_gsign_reg;
            t2_trace_reg <= t1_trace_reg;
            t2_mag_reg   <= t1_mag_reg;
            t2_shift_reg <= t2_shift_next;
        end
    end

    // stage t3: shift the magnitudes
    logic                  t3_vld_reg;
    logic                  t3_bad_reg;
    logic                  t3_zg_reg;
    logic [NG-1:0]         t3_gsign_reg;
    logic [W-1:0]          t3_trace_reg;
    logic [NG-1:0][W-1:0]  t3_smag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t3_vld_reg <= 1'b0;
        end else if (en) begin
            t3_vld_reg <= t2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t3_bad_reg   <= t2_bad_reg;
            t3_zg_reg    <= t2_zg_reg;
            t3_gsign_reg <= t2_gsign_reg;
            t3_trace_reg <= t2_trace_reg;
            for (int i = 0; i < NG; i++) begin
                t3_smag_reg[i] <= t2_mag_reg[i] << t2_shift_reg;
            end
        end
    end

    // stage t4: squares
    logic                                 t4_vld_reg;
    logic                                 t4_bad_reg;
    logic                                 t4_zg_reg;
    logic [NG-1:0]                        t4_gsign_reg;
    logic [W-1:0]                         t4_trace_reg;
    logic [NG-1:0][W-1:0]                 t4_smag_reg;
    logic [NG-1:0][mcvg_pkg::SQ_W-1:0]    t4_sq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t4_vld_reg <= 1'b0;
        end else if (en) begin
            t4_vld_reg <= t3_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t4_bad_reg   <= t3_bad_reg;
            t4_zg_reg    <= t3_zg_reg;
            t4_gsign_reg <= t3_gsign_reg;
            t4_trace_reg <= t3_trace_reg;
            t4_smag_reg  <= t3_smag_reg;
            for (int i = 0; i < NG; i++) begin
                t4_sq_reg[i] <= mcvg_pkg::SQ_W'(t3_smag_reg[i]) *
                                mcvg_pkg::SQ_W'(t3_smag_reg[i]);
            end
        end
    end

    // stage t5: sum of squares
    logic                         t5_vld_reg;
    logic                         t5_bad_reg;
    logic                         t5_zg_reg;
    logic [NG-1:0]                t5_gsign_reg;
    logic [W-1:0]                 t5_trace_reg;
    logic [NG-1:0][W-1:0]         t5_smag_reg;
    logic [mcvg_pkg::SQ_W-1:0]    t5_sumsq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t5_vld_reg <= 1'b0;
        end else if (en) begin
            t5_vld_reg <= t4_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t5_bad_reg   <= t4_bad_reg;
            t5_zg_reg    <= t4_zg_reg;
            t5_gsign_reg <= t4_gsign_reg;
            t5_trace_reg <= t4_trace_reg;
            t5_smag_reg  <= t4_smag_reg;
            t5_sumsq_reg <= t4_sq_reg[0] + t4_sq_reg[1] + t4_sq_reg[2];
        end
    end

    // norm of the shifted gradient
    logic                  rt_valid;
    logic [W-1:0]          rt_root;
    logic [RSW-1:0]        rt_side;
    logic [NG-1:0][W-1:0]  rt_smag;
    logic [NG-1:0][W-1:0]  nd_hi;
    logic [NG-1:0][F:0]    nd_lo;

    mcvg_sqrt #(.SW(RSW)) u_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (t5_vld_reg),
        .radicand  (t5_sumsq_reg),
        .side_in   ({t5_bad_reg, t5_zg_reg, t5_gsign_reg, t5_trace_reg, t5_smag_reg}),
        .out_valid (rt_valid),
        .root      (rt_root),
        .side_out  (rt_side)
    );

    // unit vector: shifted magnitude over the norm
    assign rt_smag = rt_side[NG*W-1:0];

    always_comb begin
        for (int i = 0; i < NG; i++) begin
            nd_hi[i] = {1'b0, rt_smag[i][W-1:1]};
            nd_lo[i] = {rt_smag[i][0], {F{1'b0}}};
        end
    end

    logic                nd_valid;
    logic [NG-1:0][F:0]  nd_q;
    logic [NSW-1:0]      nd_side;
    logic [W-1:0]        nd_trace;
    logic [W-1:0]        nd_trace_mag;

    mcvg_div #(.LANES(NG), .DW(W), .QW(F + 1), .SW(NSW)) u_unit_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (rt_valid),
        .num_hi    (nd_hi),
        .num_lo    (nd_lo),
        .den       (rt_root),
        .side_in   (rt_side[RSW-1:NG*W]),
        .out_valid (nd_valid),
        .quo       (nd_q),
        .side_out  (nd_side)
    );

    // a = trace / (3 - 2d)
    assign nd_trace     = nd_side[W-1:0];
    assign nd_trace_mag = nd_trace[W-1] ? ~nd_trace + 1'b1 : nd_trace;

    logic           ad_valid;
    logic [W-1:0]   ad_q;
    logic [ASW-1:0] ad_side;

    mcvg_div #(.LANES(1), .DW(F + 2), .QW(W), .SW(ASW)) u_a_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (nd_valid),
        .num_hi    ((F + 2)'(nd_trace_mag[W-1 -: F])),
        .num_lo    ({nd_trace_mag[W-1-F:0], {F{1'b0}}}),
        .den       (a_den),
        .side_in   ({nd_side, nd_q}),
        .out_valid (ad_valid),
        .quo       (ad_q),
        .side_out  (ad_side)
    );

    // stage m1: diag, outer and the direction products
    logic [NG-1:0][F:0] ad_n;
    logic [NG-1:0]      ad_gsign;
    logic [W-1:0]       ad_trace;
    logic [W+F:0]       m1_diag_prod;
    logic [W+F:0]       m1_outer_prod;

    assign ad_n     = ad_side[NG*(F+1)-1:0];
    assign ad_trace = ad_side[NG*(F+1)+W-1 -: W];
    assign ad_gsign = ad_side[NG*(F+1)+W+NG-1 -: NG];
    assign m1_diag_prod  = (W + F + 1)'(ad_q) * (W + F + 1)'(one_minus_d);
    assign m1_outer_prod = (W + F + 1)'(ad_q) * (W + F + 1)'(d_clamp);

    logic                      m1_vld_reg;
    logic                      m1_bad_reg;
    logic                      m1_zg_reg;
    logic [W-1:0]              m1_trace_reg;
    logic [W-1:0]              m1_diag_reg;
    logic [W-1:0]              m1_outer_reg;
    logic [NG*NG-1:0][F:0]     m1_p_reg;
    logic [NG*NG-1:0]          m1_pneg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_vld_reg <= 1'b0;
        end else if (en) begin
            m1_vld_reg <= ad_valid;
        end
    end

    always_ff @(posedge aclk) begin
        logic [2*F+1:0] prod;
        if (en) begin
            m1_bad_reg   <= ad_side[ASW-1];
            m1_zg_reg    <= ad_side[ASW-2];
            m1_trace_reg <= ad_trace;
            m1_diag_reg  <= m1_diag_prod[W+F-1:F];
            m1_outer_reg <= m1_outer_prod[W+F-1:F];
            for (int i = 0; i < NG; i++) begin
                for (int j = 0; j < NG; j++) begin
                    prod = (2 * F + 2)'(ad_n[i]) * (2 * F + 2)'(ad_n[j]);
                    m1_p_reg[NG*i+j]    <= prod[2*F:F];
                    m1_pneg_reg[NG*i+j] <= ad_gsign[i] ^ ad_gsign[j];
                end
            end
        end
    end

    // stage m2: outer times direction products
    logic                      m2_vld_reg;
    logic                      m2_bad_reg;
    logic                      m2_zg_reg;
    logic [W-1:0]              m2_trace_reg;
    logic [W:0]                m2_diag_reg;
    logic [NG*NG-1:0][W-1:0]   m2_v_reg;
    logic [NG*NG-1:0]          m2_vneg_reg;
    logic                      m1_aneg;

    assign m1_aneg = m1_trace_reg[W-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m2_vld_reg <= 1'b0;
        end else if (en) begin
            m2_vld_reg <= m1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        logic [W+F:0] prod;
        if (en) begin
            m2_bad_reg   <= m1_bad_reg;
            m2_zg_reg    <= m1_zg_reg;
            m2_trace_reg <= m1_trace_reg;
            m2_diag_reg  <= m1_aneg ? ~{1'b0, m1_diag_reg} + 1'b1 : {1'b0, m1_diag_reg};
            for (int k = 0; k < NG * NG; k++) begin
                prod = (W + F + 1)'(m1_outer_reg) * (W + F + 1)'(m1_p_reg[k]);
                m2_v_reg[k]    <= prod[W+F-1:F];
                m2_vneg_reg[k] <= m1_aneg ^ m1_pneg_reg[k];
            end
        end
    end

    // output register: sum, saturate and the special cases
    logic                     m_tvalid_reg;
    logic [319:0]             m_data_reg;
    logic [0:0]               m_user_reg;
    logic [NG*NG-1:0][W-1:0]  out_l;

    always_comb begin
        logic signed [33:0] v;
        logic signed [33:0] dg;
        for (int i = 0; i < NG; i++) begin
            for (int j = 0; j < NG; j++) begin
                v  = m2_vneg_reg[NG*i+j] ? -$signed({2'b00, m2_v_reg[NG*i+j]})
                                         : $signed({2'b00, m2_v_reg[NG*i+j]});
                dg = (i == j) ? $signed({m2_diag_reg[W], m2_diag_reg}) : 34'sd0;
                if (m2_bad_reg) begin
                    out_l[NG*i+j] = '0;
                end else if (m2_zg_reg) begin
                    out_l[NG*i+j] = (i == j) ? m2_trace_reg : '0;
                end else begin
                    out_l[NG*i+j] = sat34(v + dg);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= m2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= {(m2_bad_reg ? {W{1'b0}} : m2_trace_reg), out_l};
            m_user_reg <= m2_bad_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the mass-change velocity gradient block: items from
// a directed table and random draws go in, results come back and are checked
// field by field against an in-bench fixed point predictor.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 16;
    localparam longint ONE = 64'sd1 << FRAC;
    localparam int LATENCY = 2 * FRAC + 105;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic [31:0] gz;
        logic [31:0] gy;
        logic [31:0] gx;
        logic [31:0] rate;
        logic [31:0] density;
    } vg_item_t;

    typedef struct {
        logic [319:0] tensor;
        logic         bad;
    } vg_result_t;

    typedef struct {
        vg_item_t     item;
        bit           known;
        logic [319:0] tensor;
        logic         bad;
    } table_row_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_wr_en;
    logic [16:0]  cfg_wr_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [159:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [319:0] m_tdata;
    logic [0:0]   m_tuser;

    logic [mcvg_pkg::MIX_W-1:0] mix_reg;
    vg_result_t       pending_q[$];
    int               mismatches;
    int               idle_cycles;
    bit               rx_quiet;
    bit               rx_hold;
    bit               finished;

    mass_change_velocity_gradient #(.FRAC_BITS(FRAC)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned isqrt64(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // velocity gradient tensor for one item at the given mixing value
    function automatic vg_result_t velocity_gradient(vg_item_t it,
                                                     logic [mcvg_pkg::MIX_W-1:0] mix);
        vg_result_t      res;
        longint          dens, rt, tr, d, a, diag, outer, p, v;
        longint          g[3];
        longint          n[3];
        longint unsigned mag[3];
        longint unsigned big, sumsq, nrm;
        int              sh;
        dens = longint'($signed(it.density));
        rt = longint'($signed(it.rate));
        g[0] = longint'($signed(it.gx));
        g[1] = longint'($signed(it.gy));
        g[2] = longint'($signed(it.gz));
        res.tensor = '0;
        res.bad = 1'b0;
        if (dens <= 0) begin
            res.bad = 1'b1;
            return res;
        end
        tr = clamp32(rt * ONE / dens);
        res.tensor[319:288] = tr[31:0];
        if (g[0] == 0 && g[1] == 0 && g[2] == 0) begin
            for (int i = 0; i < 3; i++) res.tensor[128*i +: 32] = tr[31:0];
            return res;
        end
        d = longint'(mix);
        if (d > ONE) d = ONE;
        big = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = g[i] < 0 ? longint'(-g[i]) : longint'(g[i]);
            if (mag[i] > big) big = mag[i];
        end
        sh = 0;
        while (big < (64'd1 << 30)) begin
            big <<= 1;
            sh++;
        end
        sumsq = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] <<= sh;
            sumsq += mag[i] * mag[i];
        end
        nrm = isqrt64(sumsq);
        for (int i = 0; i < 3; i++) begin
            n[i] = longint'(mag[i] * longint'(ONE) / nrm);
            if (g[i] < 0) n[i] = -n[i];
        end
        a = tr * ONE / (3 * ONE - 2 * d);
        diag = a * (ONE - d) / ONE;
        outer = a * d / ONE;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                p = n[i] * n[j] / ONE;
                v = outer * p / ONE;
                if (i == j) v += diag;
                v = clamp32(v);
                res.tensor[32*(3*i+j) +: 32] = v[31:0];
            end
        end
        return res;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return $urandom_range(0, 65536 * 4) - 131072;
            default: return $urandom;
        endcase
    endfunction

    // mostly positive densities so the tensor path gets exercised
    function automatic vg_item_t rand_item();
        vg_item_t it;
        it.density = ($urandom_range(0, 9) == 0) ? rand_word() :
                     ($urandom_range(0, 1) ? $urandom_range(1, 32'h7FFF_FFFF)
                                           : $urandom_range(1, 65536 * 8));
        it.rate = rand_word();
        it.gx = rand_word();
        it.gy = rand_word();
        it.gz = rand_word();
        if ($urandom_range(0, 9) == 0) begin
            it.gx = 0;
            it.gy = 0;
            it.gz = 0;
        end
        return it;
    endfunction

    task automatic send_item(vg_item_t it, bit may_idle);
        int gap;
        if (may_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= it;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    task automatic write_mixing(logic [16:0] val);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        mix_reg = val;
    endtask

    // expectation queued at acceptance, from the predictor
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            pending_q.push_back(velocity_gradient(vg_item_t'(s_tdata), mix_reg));
    end

    // result check
    always @(posedge aclk) begin
        vg_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_tdata);
            end else begin
                exp_r = pending_q.pop_front();
                if (exp_r.tensor !== m_tdata || exp_r.bad !== m_tuser[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h/%b got %h/%b",
                                 exp_r.tensor, exp_r.bad, m_tdata, m_tuser[0]);
                end
            end
        end
    end

    // receiver stalls, with one long hold-off on request
    initial begin
        int gap;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
                rx_hold = 1'b0;
            end else if (!rx_quiet && $urandom_range(0, 7) == 0) begin
                gap = $urandom_range(1, 17);
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || finished) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WATCHDOG) begin
                $display("mass_change_velocity_gradient verification failed");
                $finish;
            end
        end
    end

    initial begin
        table_row_t  rows[$];
        table_row_t  r;
        logic [16:0] mixes[5];
        vg_result_t  got;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        mix_reg = '0;
        mismatches = 0;
        idle_cycles = 0;
        rx_quiet = 1'b0;
        rx_hold = 1'b0;
        finished = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table; known rows carry a hand-read result
        r.known = 1'b1;
        r.item = '{0, 0, 0, 0, 0};
        r.tensor = '0; r.bad = 1'b1; rows.push_back(r);
        r.item = '{32'h1, 32'h1, 32'h1, 32'h10000, 32'h8000_0000};
        rows.push_back(r);
        r.item = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
        rows.push_back(r);
        // zero gradient: diagonal equals trace of two
        r.item = '{0, 0, 0, 32'h20000, 32'h10000};
        r.tensor = '0; r.bad = 1'b0;
        r.tensor[319:288] = 32'h20000;
        for (int i = 0; i < 3; i++) r.tensor[128*i +: 32] = 32'h20000;
        rows.push_back(r);
        r.known = 1'b0;
        r.item = '{0, 0, 32'h10000, 32'h7FFF_FFFF, 32'h1};
        rows.push_back(r);
        r.item = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h1};
        rows.push_back(r);
        r.item = '{32'h7FFF_FFFF, 32'h1, 32'hFFFF_FFFF, 32'hFFFF_0000, 32'h7FFF_FFFF};
        rows.push_back(r);
        r.item = '{32'h1, 0, 0, 32'h7FFF_FFFF, 32'h100};
        rows.push_back(r);
        r.item = '{32'hDEAD_BEEF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0000, 32'h10000};
        rows.push_back(r);

        mixes = '{17'd0, 17'h1_0000, 17'h1_FFFF, 17'h0_8000, 17'd1};
        foreach (mixes[k]) begin
            if (k != 0) write_mixing(mixes[k]);
            foreach (rows[i]) begin
                if (rows[i].known) begin
                    got = velocity_gradient(rows[i].item, mix_reg);
                    if (got.tensor !== rows[i].tensor || got.bad !== rows[i].bad) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("table row %0d disagrees with predictor", i);
                    end
                end
                send_item(rows[i].item, 1'b0);
            end
            drain();
        end

        // random phases at several mixing settings
        for (int ph = 0; ph < 4; ph++) begin
            write_mixing(ph == 0 ? 17'h1_0000 : 17'($urandom_range(0, 17'h1_FFFF)));
            if (ph == 1) rx_hold = 1'b1;
            if (ph == 3) rx_quiet = 1'b1;
            for (int i = 0; i < 200; i++) send_item(rand_item(), ph != 3);
            drain();
        end

        finished = 1'b1;
        if (mismatches == 0 && pending_q.size() == 0) begin
            $display("mass_change_velocity_gradient verification clean");
        end else begin
            $display("mass_change_velocity_gradient verification failed");
        end
        $finish;
    end

endmodule

/* files.f */
src/mcvg_pkg.sv
src/mcvg_div.sv
src/mcvg_sqrt.sv
src/mass_change_velocity_gradient.sv
sim/tb_top.sv
